>>> sv/glsc_pkg.sv
package glsc_pkg;

  // Coordinate width of every cell field, and width of the area registers.
  localparam int CW = 6;
  localparam int GW = 7;
  // Width of the Bresenham error term; it stays within twice the largest delta.
  localparam int EW = 9;
  // Configuration bus address width: two registers at byte addresses 0 and 4.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [GW-1:0] GRID_DIM_RST = 7'd64;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic          req_type;
    logic [CW-1:0] cell_x;
    logic [CW-1:0] cell_y;
    logic          cell_blocked;
    logic [CW-1:0] from_x;
    logic [CW-1:0] from_y;
    logic [CW-1:0] to_x;
    logic [CW-1:0] to_y;
  } in_item_t;

  typedef struct packed {
    logic reply_kind;
    logic visible;
  } out_item_t;

  // Classified command handed from the front end to the engine.
  typedef struct packed {
    logic          kind;
    logic [CW-1:0] cell_x;
    logic [CW-1:0] cell_y;
    logic          cell_blocked;
    logic [CW-1:0] x0;
    logic [CW-1:0] y0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic          sx_neg;
    logic          sy_neg;
  } cmd_t;

  typedef struct packed {
    logic [GW-1:0] grid_width;
    logic [GW-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic cmd_take;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_WR_RD,
    B_WR_WB,
    B_Q_START,
    B_Q_WALK,
    B_RESULT
  } back_state_t;

endpackage

>>> sv/glsc_ram.sv
module glsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/glsc_front.sv
module glsc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  glsc_pkg::in_item_t    in_item,
  input  glsc_pkg::back_stat_t  stat,
  output logic                  cmd_valid,
  output glsc_pkg::cmd_t        cmd
);

  logic [1:0]     cnt_r, cnt_nxt;
  logic           wr_ptr_r, rd_ptr_r;
  glsc_pkg::cmd_t q_r [2];
  glsc_pkg::cmd_t cls;
  logic           accept;

  // Items are not taken while the engine sweeps the map clear.
  assign full      = (cnt_r == 2'd2) | stat.clearing;
  assign accept    = push & ~full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // Precompute the line deltas and step directions so the engine starts at once.
  always_comb begin
    cls.kind         = in_item.req_type;
    cls.cell_x       = in_item.cell_x;
    cls.cell_y       = in_item.cell_y;
    cls.cell_blocked = in_item.cell_blocked;
    cls.x0           = in_item.from_x;
    cls.y0           = in_item.from_y;
    cls.x1           = in_item.to_x;
    cls.y1           = in_item.to_y;
    cls.dx = (in_item.to_x > in_item.from_x) ? in_item.to_x - in_item.from_x
                                             : in_item.from_x - in_item.to_x;
    cls.dy = (in_item.to_y > in_item.from_y) ? in_item.to_y - in_item.from_y
                                             : in_item.from_y - in_item.to_y;
    cls.sx_neg = ~(in_item.from_x < in_item.to_x);
    cls.sy_neg = ~(in_item.from_y < in_item.to_y);
  end

  assign cnt_nxt = 2'(cnt_r + {1'b0, accept} - {1'b0, stat.cmd_take});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (stat.cmd_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> sv/glsc_back.sv
module glsc_back #(
  parameter int GRID_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  glsc_pkg::cfg_t        cfg,
  input  logic                  cmd_valid,
  input  glsc_pkg::cmd_t        cmd,
  output glsc_pkg::back_stat_t  stat,
  input  logic                  pop,
  output logic                  empty,
  output glsc_pkg::out_item_t   out_item
);

  localparam int AW = $clog2(GRID_SIDE);
  localparam int CW = glsc_pkg::CW;
  localparam int EW = glsc_pkg::EW;
  localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIDE - 1);

  function automatic logic in_side(input logic [CW-1:0] x, input logic [CW-1:0] y);
    in_side = (32'(x) < GRID_SIDE) && (32'(y) < GRID_SIDE);
  endfunction

  function automatic logic out_of_area(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                       input glsc_pkg::cfg_t c);
    out_of_area = (glsc_pkg::GW'(x) >= c.grid_width) || (glsc_pkg::GW'(y) >= c.grid_height)
                  || !in_side(x, y);
  endfunction

  glsc_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_cnt_r;
  glsc_pkg::cmd_t        cur_r;
  logic [CW-1:0]         wx_r, wy_r;
  logic signed [EW-1:0]  err_r;

  logic                  chk_v_r, chk_last_r, chk_diag_r;
  logic [CW-1:0]         chk_x_r, chk_px_r;
  logic                  chk_cell_out_r, chk_s1_out_r, chk_s2_out_r;
  logic [GRID_SIDE-1:0]  prev_row_r, rd_row, row_mod;

  logic                  vis_r, res_v_r;
  glsc_pkg::out_item_t   res_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [GRID_SIDE-1:0]  ram_wdata;

  logic                  take, issue_start, issue_step, load_res;
  logic                  at_end, fail, resolve, slot_free, clr_done;
  logic                  b_cell, b_s1, b_s2;

  logic signed [EW:0]    e2, dx_s, dy_s, err_ext, dsub, dadd, err_sum;
  logic signed [EW-1:0]  err_step, err_init;
  logic                  step_x, step_y;
  logic [CW-1:0]         nx, ny;

  // The map holds one row of cells per word.
  glsc_ram #(
    .WIDTH(GRID_SIDE),
    .DEPTH(GRID_SIDE)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_row)
  );

  // One Bresenham step from the walker position.
  always_comb begin
    e2       = $signed({err_r, 1'b0});
    dx_s     = $signed((EW+1)'(cur_r.dx));
    dy_s     = $signed((EW+1)'(cur_r.dy));
    step_x   = e2 > -dy_s;
    step_y   = e2 < dx_s;
    err_ext  = (EW+1)'(err_r);
    dsub     = step_x ? dy_s : '0;
    dadd     = step_y ? dx_s : '0;
    err_sum  = err_ext - dsub + dadd;
    err_step = EW'(err_sum);
    nx = step_x ? (cur_r.sx_neg ? wx_r - 1'b1 : wx_r + 1'b1) : wx_r;
    ny = step_y ? (cur_r.sy_neg ? wy_r - 1'b1 : wy_r + 1'b1) : wy_r;
    err_init = $signed(EW'(cmd.dx)) - $signed(EW'(cmd.dy));
  end

  assign at_end = (wx_r == cur_r.x1) && (wy_r == cur_r.y1);

  // The check stage sees the row of the new cell and keeps the row it left.
  assign b_cell  = chk_cell_out_r | rd_row[AW'(chk_x_r)];
  assign b_s1    = chk_s1_out_r | rd_row[AW'(chk_px_r)];
  assign b_s2    = chk_s2_out_r | prev_row_r[AW'(chk_x_r)];
  assign fail    = b_cell | (chk_diag_r & b_s1 & b_s2);
  assign resolve = (state_r == glsc_pkg::B_Q_WALK) && chk_v_r && (fail || chk_last_r);

  assign slot_free = ~res_v_r | pop;
  assign clr_done  = (clr_cnt_r == LAST_ROW);

  always_comb begin
    row_mod = rd_row;
    row_mod[AW'(cur_r.cell_x)] = cur_r.cell_blocked;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glsc_pkg::B_CLEAR: begin
        if (clr_done) state_nxt = glsc_pkg::B_IDLE;
      end
      glsc_pkg::B_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.kind == glsc_pkg::REQ_QUERY) ? glsc_pkg::B_Q_START
                                                       : glsc_pkg::B_WR_RD;
        end
      end
      glsc_pkg::B_WR_RD:   state_nxt = glsc_pkg::B_WR_WB;
      glsc_pkg::B_WR_WB:   state_nxt = glsc_pkg::B_RESULT;
      glsc_pkg::B_Q_START: state_nxt = glsc_pkg::B_Q_WALK;
      glsc_pkg::B_Q_WALK: begin
        if (resolve) state_nxt = glsc_pkg::B_RESULT;
      end
      glsc_pkg::B_RESULT: begin
        if (slot_free) state_nxt = glsc_pkg::B_IDLE;
      end
      default: state_nxt = glsc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = AW'(cur_r.cell_y);
    ram_wdata   = row_mod;
    ram_raddr   = AW'(cur_r.cell_y);
    take        = 1'b0;
    issue_start = 1'b0;
    issue_step  = 1'b0;
    load_res    = 1'b0;
    unique case (state_r)
      glsc_pkg::B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      glsc_pkg::B_IDLE:    take = cmd_valid;
      glsc_pkg::B_WR_RD:   ram_raddr = AW'(cur_r.cell_y);
      glsc_pkg::B_WR_WB:   ram_we = in_side(cur_r.cell_x, cur_r.cell_y);
      glsc_pkg::B_Q_START: begin
        issue_start = 1'b1;
        ram_raddr   = AW'(cur_r.y0);
      end
      glsc_pkg::B_Q_WALK: begin
        issue_step = ~at_end;
        ram_raddr  = AW'(ny);
      end
      glsc_pkg::B_RESULT:  load_res = slot_free;
      default: ;
    endcase
  end

  assign stat.clearing = (state_r == glsc_pkg::B_CLEAR);
  assign stat.cmd_take = take;
  assign empty         = ~res_v_r;
  assign out_item      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= glsc_pkg::B_CLEAR;
      clr_cnt_r <= '0;
      chk_v_r   <= 1'b0;
      res_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == glsc_pkg::B_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      chk_v_r <= issue_start | issue_step;
      res_v_r <= (res_v_r & ~pop) | load_res;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= cmd;
      wx_r  <= cmd.x0;
      wy_r  <= cmd.y0;
      err_r <= err_init;
    end
    if (issue_step) begin
      wx_r  <= nx;
      wy_r  <= ny;
      err_r <= err_step;
    end
    if (issue_start) begin
      chk_x_r        <= cur_r.x0;
      chk_px_r       <= cur_r.x0;
      chk_diag_r     <= 1'b0;
      chk_last_r     <= at_end;
      chk_cell_out_r <= out_of_area(cur_r.x0, cur_r.y0, cfg);
      chk_s1_out_r   <= 1'b0;
      chk_s2_out_r   <= 1'b0;
    end
    if (issue_step) begin
      chk_x_r        <= nx;
      chk_px_r       <= wx_r;
      chk_diag_r     <= step_x & step_y;
      chk_last_r     <= (nx == cur_r.x1) && (ny == cur_r.y1);
      chk_cell_out_r <= out_of_area(nx, ny, cfg);
      chk_s1_out_r   <= out_of_area(wx_r, ny, cfg);
      chk_s2_out_r   <= out_of_area(nx, wy_r, cfg);
    end
    if (chk_v_r) begin
      prev_row_r <= rd_row;
    end
    if (resolve) begin
      vis_r <= ~fail;
    end
    if (state_r == glsc_pkg::B_WR_WB) begin
      vis_r <= 1'b0;
    end
    if (load_res) begin
      res_r.reply_kind <= cur_r.kind;
      res_r.visible    <= vis_r;
    end
  end

endmodule

>>> sv/grid_line_of_sight_corner_check_core.sv
// Grid line-of-sight checker with a corner-cut test.
// Input words enter through push/full: a word is taken when push is high and
// full is low. A write word stores one cell's blocked bit; a query word asks
// whether the Bresenham line between two cells is clear. Every word yields one
// result word on the out_item port, shown while empty is low and taken with pop.
// A front end classifies each word into a two-deep command queue; the engine
// behind it keeps the map as one row of cells per memory word.
// A write reads its cell's map row and writes it back with the new bit. The
// walker of a query reads one map row per step, and the row it leaves is
// kept so that both side cells of a diagonal step are checked in the same
// cycle. A blocked cell ends the walk early.
// When pop stays low the finished result waits in the output register; the
// engine then holds at its result step while the command queue keeps taking
// words until it is full.
// After reset the engine clears the map, one row a cycle, through all GRID_SIDE
// rows, and full stays high meanwhile. The area registers grid_width and
// grid_height, at byte addresses 0 and 4, reset to 64.
module grid_line_of_sight_corner_check_core #(
  parameter int GRID_SIDE = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  glsc_pkg::in_item_t                in_item,
  output logic                              empty,
  input  logic                              pop,
  output glsc_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [glsc_pkg::PADDR_W-1:0]      paddr,
  input  logic [glsc_pkg::PDATA_W-1:0]      pwdata,
  output logic [glsc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  logic [glsc_pkg::GW-1:0] grid_width_r, grid_height_r;
  glsc_pkg::cfg_t          cfg;
  glsc_pkg::reg_idx_t      reg_sel;
  glsc_pkg::back_stat_t    stat;
  glsc_pkg::cmd_t          cmd;
  logic                    cmd_valid;
  logic                    cfg_wr;

  // Registers sit on word boundaries, so bit 2 of the address picks one.
  assign reg_sel = glsc_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= glsc_pkg::GRID_DIM_RST;
      grid_height_r <= glsc_pkg::GRID_DIM_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        glsc_pkg::REG_GRID_WIDTH:  grid_width_r  <= pwdata[glsc_pkg::GW-1:0];
        glsc_pkg::REG_GRID_HEIGHT: grid_height_r <= pwdata[glsc_pkg::GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      glsc_pkg::REG_GRID_WIDTH:  prdata = glsc_pkg::PDATA_W'(grid_width_r);
      glsc_pkg::REG_GRID_HEIGHT: prdata = glsc_pkg::PDATA_W'(grid_height_r);
      default: ;
    endcase
  end

  assign cfg.grid_width  = grid_width_r;
  assign cfg.grid_height = grid_height_r;

  glsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .stat     (stat),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  glsc_back #(
    .GRID_SIDE(GRID_SIDE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .stat     (stat),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
